>>> hdl/fgn2d_pkg.sv
// Shared constants, types and table functions for the fractal gradient noise block.
package fgn2d_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_OCTAVES_DEF = 8;
    localparam int SINE_BITS_DEF   = 10;

    // Corner hash multipliers
    localparam logic [31:0] HASH_M1 = 32'd3284157443;
    localparam logic [31:0] HASH_M2 = 32'd1911520717;
    localparam logic [31:0] HASH_M3 = 32'd2048419325;

    // 1/sqrt(2) in Q.32
    localparam logic [31:0] INV_ROOT2 = 32'd3037000500;

    // Datapath widths
    localparam int PROD_W = 49;   // point * base frequency
    localparam int N_W    = 36;   // dot products and blends
    localparam int TERM_W = 53;   // octave value times amplitude

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES   = 2'd2;

    localparam logic [15:0] AMP_RST  = 16'd16384;
    localparam logic [15:0] FREQ_RST = 16'd256;
    localparam logic [3:0]  OCT_RST  = 4'd4;

    // sin(pi/2*u) polynomial coefficients, Q.30
    localparam longint SC1 = 64'sd1686629713;
    localparam longint SC3 = -64'sd693598343;
    localparam longint SC5 = 64'sd85569306;
    localparam longint SC7 = -64'sd5026995;
    localparam longint SC9 = 64'sd172272;

    typedef struct packed {
        logic        on;
        logic [15:0] amp;
    } fgn2d_lane_cfg_t;

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // Quarter-wave sine of a Q.16 phase, Q.15 result clamped to [0, 1]
    function automatic longint qsine(input longint u);
        longint u2;
        longint acc;
        longint r;
        u2  = (u * u) >>> 16;
        acc = SC9;
        acc = SC7 + ((acc * u2) >>> 16);
        acc = SC5 + ((acc * u2) >>> 16);
        acc = SC3 + ((acc * u2) >>> 16);
        acc = SC1 + ((acc * u2) >>> 16);
        r   = (((acc * u) >>> 16) + 64'sd16384) >>> 15;
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 32768)
        begin
            r = 32768;
        end
        return r;
    endfunction

endpackage

>>> hdl/fgn2d_octave.sv
// One octave lane: cell split, corner hash, gradients, smootherstep blend, amplitude.
module fgn2d_octave #(
    parameter int OCTAVE          = 0,
    parameter int SINE_TABLE_BITS = fgn2d_pkg::SINE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic signed [fgn2d_pkg::PROD_W-1:0]   prod_x,
    input  logic signed [fgn2d_pkg::PROD_W-1:0]   prod_y,
    input  fgn2d_pkg::fgn2d_lane_cfg_t            lane_cfg,
    output logic signed [fgn2d_pkg::TERM_W-1:0]   term
);
    import fgn2d_pkg::*;

    localparam int B  = SINE_TABLE_BITS;
    localparam int QN = 1 << (B - 2);
    localparam logic [B-2:0] QN_I = (B-1)'(QN);
    localparam logic [B-1:0] QN_P = B'(QN);

    // Quarter-wave table, built at elaboration
    logic [15:0] qsin [QN+1];
    for (genvar k = 0; k <= QN; k++)
    begin : g_sin
        assign qsin[k] = 16'(qsine(longint'(k) << (18 - B)));
    end

    // Stage 1: scale by octave, split into cell corner and fraction
    logic signed [63:0] sh_x, sh_y;
    assign sh_x = 64'(prod_x) <<< OCTAVE;
    assign sh_y = 64'(prod_y) <<< OCTAVE;

    logic [31:0] cx_reg [2];
    logic [31:0] cy_reg [2];
    logic [15:0] w1_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= sh_x[55:24];
            cx_reg[1] <= sh_x[55:24] + 32'd1;
            cy_reg[0] <= sh_y[55:24];
            cy_reg[1] <= sh_y[55:24] + 32'd1;
            w1_reg[0] <= sh_x[23:8];
            w1_reg[1] <= sh_y[23:8];
        end
    end

    // Stage 2: first hash multiply; smootherstep polynomial and square
    logic [31:0] ax2_reg [2];
    logic [31:0] cy2_reg [2];
    logic [15:0] w2_reg  [2];
    logic [20:0] t2_reg  [2];
    logic [15:0] sq2_reg [2];
    logic [20:0] t_next  [2];
    logic [15:0] sq_next [2];

    always_comb
    begin
        logic signed [21:0] lin;
        logic signed [38:0] tp;
        logic signed [38:0] tf;
        logic [31:0]        sq;
        for (int a = 0; a < 2; a++)
        begin
            lin        = 22'(6 * int'(w1_reg[a]) - 983040);
            tp         = $signed({1'b0, w1_reg[a]}) * lin;
            tf         = (tp >>> 16) + 39'sd655360;
            t_next[a]  = tf[20:0];
            sq         = w1_reg[a] * w1_reg[a];
            sq_next[a] = sq[31:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 2; j++)
            begin
                ax2_reg[j] <= cx_reg[j] * HASH_M1;
                cy2_reg[j] <= cy_reg[j];
                w2_reg[j]  <= w1_reg[j];
                t2_reg[j]  <= t_next[j];
                sq2_reg[j] <= sq_next[j];
            end
        end
    end

    // Stage 3: second hash multiply per corner; cube of the fraction
    logic [31:0] bb3_reg  [4];
    logic [31:0] ax3_reg  [2];
    logic [15:0] w3_reg   [2];
    logic [20:0] t3_reg   [2];
    logic [15:0] cub3_reg [2];
    logic [15:0] cub_next [2];

    always_comb
    begin
        logic [31:0] cube;
        for (int a = 0; a < 2; a++)
        begin
            cube        = sq2_reg[a] * w2_reg[a];
            cub_next[a] = cube[31:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                bb3_reg[k] <= (cy2_reg[k >> 1] ^ rot16(ax2_reg[k & 1])) * HASH_M2;
            end
            for (int j = 0; j < 2; j++)
            begin
                ax3_reg[j]  <= ax2_reg[j];
                w3_reg[j]   <= w2_reg[j];
                t3_reg[j]   <= t2_reg[j];
                cub3_reg[j] <= cub_next[j];
            end
        end
    end

    // Stage 4: last hash multiply, keep the phase; blend weight
    logic [B-1:0] ph4_reg [4];
    logic [15:0]  w4_reg  [2];
    logic [17:0]  s4_reg  [2];
    logic [B-1:0] ph_next [4];
    logic [17:0]  s_next  [2];

    always_comb
    begin
        logic [31:0] hh;
        logic [36:0] sp;
        for (int k = 0; k < 4; k++)
        begin
            hh         = (ax3_reg[k & 1] ^ rot16(bb3_reg[k])) * HASH_M3;
            ph_next[k] = hh[31:32-B];
        end
        for (int a = 0; a < 2; a++)
        begin
            sp        = t3_reg[a] * cub3_reg[a];
            s_next[a] = sp[33:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ph4_reg[k] <= ph_next[k];
            end
            for (int j = 0; j < 2; j++)
            begin
                w4_reg[j] <= w3_reg[j];
                s4_reg[j] <= s_next[j];
            end
        end
    end

    // Stage 5: gradient lookup, x = sin(phase), y = cos(phase)
    logic signed [16:0] gx5_reg [4];
    logic signed [16:0] gy5_reg [4];
    logic [15:0]        w5_reg  [2];
    logic [17:0]        s5_reg  [2];
    logic signed [16:0] gx_next [4];
    logic signed [16:0] gy_next [4];

    always_comb
    begin
        logic [B-1:0]       ph;
        logic [1:0]         quad;
        logic [B-2:0]       idx;
        logic signed [16:0] mag;
        for (int k = 0; k < 4; k++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                ph   = (c == 1) ? ph4_reg[k] + QN_P : ph4_reg[k];
                quad = ph[B-1:B-2];
                idx  = quad[0] ? QN_I - {1'b0, ph[B-3:0]} : {1'b0, ph[B-3:0]};
                mag  = $signed({1'b0, qsin[idx]});
                if (c == 1)
                begin
                    gy_next[k] = quad[1] ? -mag : mag;
                end
                else
                begin
                    gx_next[k] = quad[1] ? -mag : mag;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                gx5_reg[k] <= gx_next[k];
                gy5_reg[k] <= gy_next[k];
            end
            for (int j = 0; j < 2; j++)
            begin
                w5_reg[j] <= w4_reg[j];
                s5_reg[j] <= s4_reg[j];
            end
        end
    end

    // Stage 6: corner dot products with the offsets
    logic signed [N_W-1:0] d6_reg [4];
    logic [17:0]           s6_reg [2];
    logic signed [N_W-1:0] d_next [4];

    always_comb
    begin
        logic signed [17:0] ox, oy;
        logic signed [34:0] mx, my;
        for (int k = 0; k < 4; k++)
        begin
            ox = $signed({2'b00, w5_reg[0]});
            oy = $signed({2'b00, w5_reg[1]});
            if ((k & 1) == 1)
            begin
                ox = ox - 18'sd65536;
            end
            if ((k >> 1) == 1)
            begin
                oy = oy - 18'sd65536;
            end
            mx        = ox * gx5_reg[k];
            my        = oy * gy5_reg[k];
            d_next[k] = N_W'(mx) + N_W'(my);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                d6_reg[k] <= d_next[k];
            end
            s6_reg[0] <= s5_reg[0];
            s6_reg[1] <= s5_reg[1];
        end
    end

    // Stage 7: blend along x, one row each
    logic signed [N_W-1:0] u7_reg [2];
    logic [17:0]           sy7_reg;
    logic signed [N_W-1:0] u_next [2];

    always_comb
    begin
        logic signed [N_W:0]    diff;
        logic signed [N_W+19:0] bp;
        for (int r = 0; r < 2; r++)
        begin
            diff      = (N_W+1)'(d6_reg[2*r+1]) - (N_W+1)'(d6_reg[2*r]);
            bp        = diff * $signed({1'b0, s6_reg[0]});
            u_next[r] = d6_reg[2*r] + N_W'(bp >>> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u7_reg[0] <= u_next[0];
            u7_reg[1] <= u_next[1];
            sy7_reg   <= s6_reg[1];
        end
    end

    // Stage 8: blend along y
    logic signed [N_W-1:0]  n8_reg;
    logic signed [N_W:0]    ydiff;
    logic signed [N_W+19:0] ybp;

    assign ydiff = (N_W+1)'(u7_reg[1]) - (N_W+1)'(u7_reg[0]);
    assign ybp   = ydiff * $signed({1'b0, sy7_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n8_reg <= u7_reg[0] + N_W'(ybp >>> 16);
        end
    end

    // Stage 9: weight by amplitude, drop octaves beyond the count
    logic signed [TERM_W-1:0] term_reg;
    logic signed [TERM_W-1:0] amp_prod;

    assign amp_prod = n8_reg * $signed({1'b0, lane_cfg.amp});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg <= lane_cfg.on ? amp_prod : '0;
        end
    end

    assign term = term_reg;

endmodule

>>> hdl/fractal_gradient_noise_2d.sv
// Top level of the fractal 2-D gradient noise block: config, octave lanes, sum, normalize.
// Throughput: one point per cycle unless the output stalls; every octave has its own
// lane, and the rate is set by the three-multiply corner hash and the blend multipliers,
// each given a stage of its own.
// A stalled output freezes the pipeline only when its last stage holds a result.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults.
module fractal_gradient_noise_2d #(
    parameter int MAX_OCTAVES     = fgn2d_pkg::MAX_OCTAVES_DEF,
    parameter int SINE_TABLE_BITS = fgn2d_pkg::SINE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // point channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  point_x,
    input  logic signed [31:0]                  point_y,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [15:0]                         noise_value,
    output logic                                clipped,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fgn2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);
    import fgn2d_pkg::*;

    localparam int TREE_L = $clog2(MAX_OCTAVES);
    localparam int LEAVES = 1 << TREE_L;
    localparam int SUM_W  = TERM_W + TREE_L;
    localparam int R_W    = SUM_W - 25;
    localparam int MUL_W  = R_W + 33;
    // front multiply, nine lane stages, adder tree, normalize multiply
    localparam int PIPE_N = 11 + TREE_L;
    localparam logic [4:0] MAX_OCT_V = 5'(MAX_OCTAVES);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an unknown index
    // is dropped. The user must write only while the pipeline is empty; not enforced.
    // ------------------------------------------------------------------
    logic [15:0] amp_reg;
    logic [15:0] freq_reg;
    logic [3:0]  oct_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg  <= AMP_RST;
            freq_reg <= FREQ_RST;
            oct_reg  <= OCT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AMPLITUDE: amp_reg  <= cfg_data;
                CFG_FREQUENCY: freq_reg <= cfg_data;
                CFG_OCTAVES:   oct_reg  <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    // Octave count saturates at the number of lanes
    logic [4:0] oct_eff;
    assign oct_eff = ({1'b0, oct_reg} > MAX_OCT_V) ? MAX_OCT_V : {1'b0, oct_reg};

    // ------------------------------------------------------------------
    // Flow control. The whole pipeline moves on one enable; it holds only
    // when a finished result sits in the last stage and the output register
    // is full and stalled. Bubbles at the tail are squeezed out.
    // ------------------------------------------------------------------
    logic [PIPE_N-1:0] vld_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              adv;

    assign out_free = !out_valid_reg || !out_stall;
    assign adv      = !vld_reg[PIPE_N-1] || out_free;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_N-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Front stage: scale both coordinates by the base frequency once; the
    // lanes apply their own octave doubling as a shift.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] px_prod_reg;
    logic signed [PROD_W-1:0] py_prod_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_prod_reg <= point_x * $signed({1'b0, freq_reg});
            py_prod_reg <= point_y * $signed({1'b0, freq_reg});
        end
    end

    // ------------------------------------------------------------------
    // Octave lanes, all in step, one weighted octave value each.
    // ------------------------------------------------------------------
    fgn2d_lane_cfg_t          lane_cfg [MAX_OCTAVES];
    logic signed [TERM_W-1:0] term     [MAX_OCTAVES];

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_lane
        assign lane_cfg[o].on  = 5'(o) < oct_eff;
        assign lane_cfg[o].amp = amp_reg >> o;

        fgn2d_octave #(
            .OCTAVE          (o),
            .SINE_TABLE_BITS (SINE_TABLE_BITS)
        ) u_octave (
            .clk      (clk),
            .adv      (adv),
            .prod_x   (px_prod_reg),
            .prod_y   (py_prod_reg),
            .lane_cfg (lane_cfg[o]),
            .term     (term[o])
        );
    end

    // ------------------------------------------------------------------
    // Registered adder tree over the lanes, padded to a power of two.
    // Node j has children 2j+1 and 2j+2; the bottom row reads the lanes.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] leaf [LEAVES];
    logic signed [SUM_W-1:0] sum_root;

    for (genvar k = 0; k < LEAVES; k++)
    begin : g_leaf
        if (k < MAX_OCTAVES)
        begin : g_used
            assign leaf[k] = SUM_W'(term[k]);
        end
        else
        begin : g_pad
            assign leaf[k] = '0;
        end
    end

    if (TREE_L == 0)
    begin : g_notree
        assign sum_root = leaf[0];
    end
    else
    begin : g_tree
        logic signed [SUM_W-1:0] node_reg [LEAVES-1];
        for (genvar j = 0; j < LEAVES - 1; j++)
        begin : g_node
            logic signed [SUM_W-1:0] lhs, rhs;
            if (2*j + 1 >= LEAVES - 1)
            begin : g_bottom
                assign lhs = leaf[2*j + 1 - (LEAVES - 1)];
                assign rhs = leaf[2*j + 2 - (LEAVES - 1)];
            end
            else
            begin : g_inner
                assign lhs = node_reg[2*j + 1];
                assign rhs = node_reg[2*j + 2];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    node_reg[j] <= lhs + rhs;
                end
            end
        end
        assign sum_root = node_reg[0];
    end

    // ------------------------------------------------------------------
    // Normalize: drop to Q.20, scale by 1/sqrt2, round, center at one half.
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0] norm_reg;
    logic signed [R_W-1:0]   sum_q20;

    assign sum_q20 = sum_root[SUM_W-1:25];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_reg <= sum_q20 * $signed({1'b0, INV_ROOT2});
        end
    end

    logic signed [MUL_W-1:0] rounded;
    logic signed [MUL_W-1:0] centered;
    logic                    under;
    logic                    over;
    logic [15:0]             value_next;

    assign rounded  = norm_reg + MUL_W'(64'sd34359738368);
    assign centered = (rounded >>> 36) + MUL_W'(32768);
    assign under    = centered[MUL_W-1];
    assign over     = !under && (centered > MUL_W'(65535));

    always_comb
    begin
        if (under)
        begin
            value_next = 16'd0;
        end
        else if (over)
        begin
            value_next = 16'hFFFF;
        end
        else
        begin
            value_next = centered[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while the receiver stalls, load whenever free.
    // ------------------------------------------------------------------
    logic [15:0] value_reg;
    logic        clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= vld_reg[PIPE_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && vld_reg[PIPE_N-1])
        begin
            value_reg <= value_next;
            clip_reg  <= under || over;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = value_reg;
    assign clipped     = clip_reg;

endmodule

>>> test/tb.sv
// Self-checking testbench for the fractal 2-D gradient noise block.
module tb;
    import fgn2d_pkg::*;

    localparam int OCT_LIMIT = 8;
    localparam int SB = 10;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
    } point_t;

    typedef struct {
        logic [15:0] level;
        logic        sat;
    } noise_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic out_valid;
    logic out_stall;
    logic [15:0] noise_value;
    logic clipped;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    // predictor copy of the registers
    logic [15:0] amp_q;
    logic [15:0] freq_q;
    logic [3:0]  oct_q;

    point_t pending_points[$];
    noise_t expected_noise[$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    bit stimulus_done;

    fractal_gradient_noise_2d uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .noise_value(noise_value), .clipped(clipped),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // floor division by 2^k for signed values
    function automatic longint fdiv(input longint v, input int k);
        return v >>> k;
    endfunction

    function automatic longint quarter_wave(input longint u);
        longint u2;
        longint acc;
        longint r;
        u2  = fdiv(u * u, 16);
        acc = 64'sd172272;
        acc = -64'sd5026995 + fdiv(acc * u2, 16);
        acc = 64'sd85569306 + fdiv(acc * u2, 16);
        acc = -64'sd693598343 + fdiv(acc * u2, 16);
        acc = 64'sd1686629713 + fdiv(acc * u2, 16);
        r = fdiv(fdiv(acc * u, 16) + 16384, 15);
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 32768)
        begin
            r = 32768;
        end
        return r;
    endfunction

    function automatic longint phase_to_sine(input logic [SB-1:0] ph);
        logic [1:0] quad;
        longint u;
        longint s;
        quad = ph[SB-1:SB-2];
        u = longint'(ph[SB-3:0]) << (18 - SB);
        s = quad[0] ? quarter_wave(65536 - u) : quarter_wave(u);
        return quad[1] ? -s : s;
    endfunction

    function automatic void gradient_at(input logic [31:0] cx, input logic [31:0] cy,
                                        output longint gx, output longint gy);
        logic [31:0] a;
        logic [31:0] b;
        logic [SB-1:0] ph;
        a = cx * 32'd3284157443;
        b = cy ^ {a[15:0], a[31:16]};
        b = b * 32'd1911520717;
        a = a ^ {b[15:0], b[31:16]};
        a = a * 32'd2048419325;
        ph = a[31:32-SB];
        gx = phase_to_sine(ph);
        gy = phase_to_sine(ph + SB'(1 << (SB - 2)));
    endfunction

    function automatic longint fade(input longint w);
        longint t;
        longint w3;
        t = fdiv(w * (6 * w - 15 * 65536), 16) + 10 * 65536;
        w3 = fdiv(fdiv(w * w, 16) * w, 16);
        return fdiv(t * w3, 16);
    endfunction

    function automatic longint lerp_q16(input longint a0, input longint a1, input longint s);
        return a0 + fdiv((a1 - a0) * s, 16);
    endfunction

    function automatic longint lattice_noise(input longint sx, input longint sy);
        logic [31:0] x0;
        logic [31:0] y0;
        longint fx;
        longint fy;
        longint dx1;
        longint dy1;
        longint gx;
        longint gy;
        longint d00;
        longint d10;
        longint d01;
        longint d11;
        longint wx;
        longint wy;
        x0 = 32'(fdiv(sx, 16));
        y0 = 32'(fdiv(sy, 16));
        fx = sx & 64'hFFFF;
        fy = sy & 64'hFFFF;
        dx1 = fx - 65536;
        dy1 = fy - 65536;
        gradient_at(x0, y0, gx, gy);
        d00 = fx * gx + fy * gy;
        gradient_at(x0 + 1, y0, gx, gy);
        d10 = dx1 * gx + fy * gy;
        gradient_at(x0, y0 + 1, gx, gy);
        d01 = fx * gx + dy1 * gy;
        gradient_at(x0 + 1, y0 + 1, gx, gy);
        d11 = dx1 * gx + dy1 * gy;
        wx = fade(fx);
        wy = fade(fy);
        return lerp_q16(lerp_q16(d00, d10, wx), lerp_q16(d01, d11, wx), wy);
    endfunction

    function automatic noise_t fractal_noise(input point_t p);
        noise_t res;
        int n;
        longint sum;
        longint f;
        longint a;
        longint r;
        longint v;
        n = (oct_q > OCT_LIMIT) ? OCT_LIMIT : int'(oct_q);
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            f = longint'(freq_q) << i;
            a = longint'(amp_q >> i);
            sum += lattice_noise(fdiv(longint'(p.px) * f, 8),
                                 fdiv(longint'(p.py) * f, 8)) * a;
        end
        r = fdiv(sum, 25);
        v = fdiv(r * 64'sd3037000500 + (64'sd1 << 35), 36) + 32768;
        res.sat = 1'b0;
        if (v < 0)
        begin
            v = 0;
            res.sat = 1'b1;
        end
        if (v > 65535)
        begin
            v = 65535;
            res.sat = 1'b1;
        end
        res.level = v[15:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver: present points from the pending queue; hold the payload while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            point_x  <= '0;
            point_y  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_noise.push_back(fractal_noise(pending_points.pop_front()));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    point_x  <= pending_points[0].px;
                    point_y  <= pending_points[0].py;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation; stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_noise.size() == 0)
                begin
                    report_mismatch("result with nothing expected");
                end
                else
                begin
                    if (noise_value !== expected_noise[0].level)
                    begin
                        report_mismatch($sformatf("noise_value %0d, expected %0d",
                                        noise_value, expected_noise[0].level));
                    end
                    if (clipped !== expected_noise[0].sat)
                    begin
                        report_mismatch($sformatf("clipped %0b, expected %0b",
                                        clipped, expected_noise[0].sat));
                    end
                    void'(expected_noise.pop_front());
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic push_point(input logic [31:0] x, input logic [31:0] y);
        point_t p;
        p.px = x;
        p.py = y;
        pending_points.push_back(p);
    endtask

    // Wait for the block to drain, then let the pipeline settle.
    task automatic drain();
        while (pending_points.size() > 0 || in_valid || expected_noise.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
    endtask

    // Write one register through the config channel; mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_AMPLITUDE: amp_q  = val;
            CFG_FREQUENCY: freq_q = val;
            CFG_OCTAVES:   oct_q  = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] a, input logic [15:0] f, input logic [3:0] o);
        write_reg(CFG_AMPLITUDE, a);
        write_reg(CFG_FREQUENCY, f);
        write_reg(CFG_OCTAVES, {12'd0, o});
    endtask

    // Random point: mostly modest coordinates, sometimes full-range ones.
    task automatic random_points(input int count);
        logic [31:0] x;
        logic [31:0] y;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                x = $urandom;
                y = $urandom;
            end
            else
            begin
                x = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
                y = $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
            end
            push_point(x, y);
        end
    endtask

    // Sequence: reset, directed points, then random phases across register settings.
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mismatches = 0;
        stimulus_done = 1'b0;
        amp_q  = 16'd16384;
        freq_q = 16'd256;
        oct_q  = 4'd4;
        send_idle_pct = 35;
        recv_idle_pct = 86;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: origin, extremes, cell edges, negative coordinates, at reset values
        push_point(32'h0, 32'h0);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h8000_0000, 32'h8000_0000);
        push_point(32'h7FFF_FFFF, 32'h8000_0000);
        push_point(32'hFFFF_FFFF, 32'h0000_FFFF);
        push_point(32'hFFFF_0000, 32'h0001_0000);
        push_point(32'h0000_8000, 32'hFFFF_8000);
        push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_point(32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        // zero octaves gives the midpoint
        set_regs(16'd16384, 16'd256, 4'd0);
        push_point(32'h1234_5678, 32'h8765_4321);
        random_points(4);
        drain();

        // octave count above the limit, maximal amplitude: drives saturation
        set_regs(16'hFFFF, 16'hFFFF, 4'd15);
        push_point(32'h7FFF_FFFF, 32'h8000_0000);
        random_points(150);
        drain();

        set_regs(16'd0, 16'd0, 4'd1);
        random_points(50);
        drain();

        set_regs(16'hFFFF, 16'd256, 4'd8);
        random_points(300);
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 35;
        set_regs(16'd16384, 16'd256, 4'd4);
        random_points(500);
        drain();

        set_regs(16'h4000 + 16'($urandom_range(16'h3FFF)), 16'($urandom), 4'd9);
        random_points(300);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(16'($urandom), 16'($urandom_range(1024)), 4'($urandom_range(1, 8)));
        random_points(400);
        drain();

        set_regs(16'hFFFF, 16'd512, 4'd8);
        random_points(300);
        drain();

        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Give up after a generous fixed time.
    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
